// ----- src/sbpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small block pool allocator package
// Shared constants, codes, payload and controller interface types.
// ----------------------------------------------------------------------------
package sbpa_pkg;

  localparam int unsigned POOL_CHUNKS = 16;
  localparam int unsigned CHUNK_WORDS = 8;
  localparam int unsigned IDX_W       = $clog2(POOL_CHUNKS);
  localparam int unsigned CNT_W       = $clog2(POOL_CHUNKS + 1);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_GRANTED        = 3'd0,
    ST_FALLBACK_ALLOC = 3'd1,
    ST_FREED          = 3'd2,
    ST_FALLBACK_FREE  = 3'd3,
    ST_DOUBLE_FREE    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EVAL,
    FSM_SCAN,
    FSM_RESULT
  } fsm_e;

  typedef struct packed {
    logic        operation;
    logic [31:0] request_size;
    logic        in_pool;
    logic [3:0]  free_chunk;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] chunk_index;
    logic [4:0] used_count;
  } res_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic grantable;
    logic scan_hit;
  } stat_t;

endpackage

// ----- src/sbpa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small block pool allocator controller
// Sequences load, evaluate, next-fit scan and result commit per request.
// ----------------------------------------------------------------------------
module sbpa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  sbpa_pkg::stat_t stat_i,
  output sbpa_pkg::cmd_t  cmd_o
);

  sbpa_pkg::fsm_e state_q, state_d;
  logic           out_valid_q, out_valid_d;
  logic           slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sbpa_pkg::FSM_IDLE: begin
        if (in_valid_i) state_d = sbpa_pkg::FSM_EVAL;
      end
      sbpa_pkg::FSM_EVAL: begin
        state_d = stat_i.grantable ? sbpa_pkg::FSM_SCAN : sbpa_pkg::FSM_RESULT;
      end
      sbpa_pkg::FSM_SCAN: begin
        if (stat_i.scan_hit) state_d = sbpa_pkg::FSM_RESULT;
      end
      sbpa_pkg::FSM_RESULT: begin
        if (slot_free) state_d = sbpa_pkg::FSM_IDLE;
      end
      default: state_d = sbpa_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      sbpa_pkg::FSM_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      sbpa_pkg::FSM_EVAL:   cmd_o.eval = 1'b1;
      sbpa_pkg::FSM_SCAN:   cmd_o.scan = 1'b1;
      sbpa_pkg::FSM_RESULT: cmd_o.commit = slot_free;
      default:              cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbpa_pkg::FSM_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- src/sbpa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small block pool allocator datapath
// Holds the used flags, search position, chunk count and result register.
// ----------------------------------------------------------------------------
module sbpa_datapath #(
  parameter int unsigned ChunkWords = sbpa_pkg::CHUNK_WORDS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sbpa_pkg::req_t  in_req_i,
  input  sbpa_pkg::cmd_t  cmd_i,
  output sbpa_pkg::stat_t stat_o,
  output sbpa_pkg::res_t  out_res_o
);

  localparam int unsigned IdxW = sbpa_pkg::IDX_W;
  localparam int unsigned CntW = sbpa_pkg::CNT_W;
  localparam logic [31:0] SizeLimit = 32'(4 * ChunkWords);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(sbpa_pkg::POOL_CHUNKS - 1);

  sbpa_pkg::req_t                 req_q;
  logic [sbpa_pkg::POOL_CHUNKS-1:0] flags_q, flags_d;
  logic [IdxW-1:0]                search_q, search_d;
  logic [CntW-1:0]                count_q, count_d;
  logic [IdxW-1:0]                scan_q;
  sbpa_pkg::status_e              res_status_q, eval_status;
  logic [IdxW-1:0]                res_idx_q, eval_idx;
  sbpa_pkg::res_t                 out_q;
  logic                           fits, full, idx_ok;

  assign fits   = req_q.request_size <= SizeLimit;
  assign full   = count_q >= CntW'(sbpa_pkg::POOL_CHUNKS);
  assign idx_ok = 32'(req_q.free_chunk) < sbpa_pkg::POOL_CHUNKS;

  assign stat_o.grantable = (req_q.operation == sbpa_pkg::OP_ALLOC) && fits && !full;
  assign stat_o.scan_hit  = !flags_q[scan_q];

  always_comb begin
    eval_status = sbpa_pkg::ST_FALLBACK_ALLOC;
    eval_idx    = '0;
    if (req_q.operation == sbpa_pkg::OP_FREE) begin
      if (!req_q.in_pool || !idx_ok) begin
        eval_status = sbpa_pkg::ST_FALLBACK_FREE;
      end else if (!flags_q[req_q.free_chunk]) begin
        eval_status = sbpa_pkg::ST_DOUBLE_FREE;
      end else begin
        eval_status = sbpa_pkg::ST_FREED;
        eval_idx    = req_q.free_chunk;
      end
    end
  end

  always_comb begin
    flags_d  = flags_q;
    search_d = search_q;
    count_d  = count_q;
    case (res_status_q)
      sbpa_pkg::ST_GRANTED: begin
        flags_d[res_idx_q] = 1'b1;
        search_d           = res_idx_q;
        count_d            = count_q + CntW'(1);
      end
      sbpa_pkg::ST_FREED: begin
        flags_d[res_idx_q] = 1'b0;
        search_d           = res_idx_q;
        if (count_q != '0) count_d = count_q - CntW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_req_i;
    if (cmd_i.eval) begin
      res_status_q <= eval_status;
      res_idx_q    <= eval_idx;
      scan_q       <= search_q;
    end
    if (cmd_i.scan) begin
      if (!flags_q[scan_q]) begin
        res_status_q <= sbpa_pkg::ST_GRANTED;
        res_idx_q    <= scan_q;
      end else begin
        scan_q <= (scan_q == LastIdx) ? '0 : scan_q + IdxW'(1);
      end
    end
    if (cmd_i.commit) begin
      out_q.status      <= res_status_q;
      out_q.chunk_index <= res_idx_q;
      out_q.used_count  <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q  <= '0;
      search_q <= '0;
      count_q  <= '0;
    end else if (cmd_i.commit) begin
      flags_q  <= flags_d;
      search_q <= search_d;
      count_q  <= count_d;
    end
  end

  assign out_res_o = out_q;

endmodule

// ----- src/small_block_pool_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small block pool allocator
// Next-fit allocator for a pool of fixed-size chunks with one used flag each.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one allocate or free request.
// Output channel: out_valid_o / out_stall_i carry one result per request:
// status, chunk index and the pool use count after the request.
// One request is in work at a time. A request is taken only while the
// controller is idle; it is then evaluated, scanned if it is a grantable
// allocate, and written to the output register.
// After acceptance a request is evaluated; a grant then adds a scan that
// steps over the used chunks from the search position (the scan tests one
// flag per cycle) before the result is valid. A new request is taken the
// cycle after the result is written, so requests never overlap in work.
// A stalled result holds in the output register; the next request is still
// taken and worked on, and waits for the register before it is written.
// Reset clears all used flags, the search position and the count at once.
// ----------------------------------------------------------------------------
module small_block_pool_allocator #(
  parameter int unsigned ChunkWords = sbpa_pkg::CHUNK_WORDS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  sbpa_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sbpa_pkg::res_t out_res_o
);

  sbpa_pkg::cmd_t  cmd;
  sbpa_pkg::stat_t stat;

  sbpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sbpa_datapath #(
    .ChunkWords (ChunkWords)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_res_o (out_res_o)
  );

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one still in work");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(out_res_o.used_count) <= sbpa_pkg::POOL_CHUNKS)
    else $error("used count exceeds pool size");

  a_index_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.status != sbpa_pkg::ST_GRANTED &&
    out_res_o.status != sbpa_pkg::ST_FREED |-> out_res_o.chunk_index == '0)
    else $error("chunk index set on a fallback or double free result");

  a_grant_not_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.status == sbpa_pkg::ST_GRANTED |->
    out_res_o.used_count != '0)
    else $error("grant reported with an empty pool count");

endmodule
